// ===== src/cla_pkg.sv =====
// Shared types and constants of the CR/LF line assembler.
package cla_pkg;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef enum logic
    {
        CMD_RAW  = 1'b0,
        CMD_LINE = 1'b1
    } cmd_kind_t;

    typedef enum logic
    {
        KIND_RAW  = 1'b0,
        KIND_LINE = 1'b1
    } out_kind_t;

endpackage

// ===== src/cla_if.sv =====
// Channel interfaces of the CR/LF line assembler: receive bytes, results and configuration.
interface cla_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cla_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_kind;
    logic       end_of_run;

    modport source (output valid, output out_byte, output out_kind, output end_of_run,
                    input ready);
    modport sink (input valid, input out_byte, input out_kind, input end_of_run,
                  output ready);
endinterface

interface cla_cfg_if;
    logic valid;
    logic ready;
    logic passthrough_mode;

    modport source (output valid, output passthrough_mode, input ready);
    modport sink (input valid, input passthrough_mode, output ready);
endinterface

// ===== src/crlf_line_assembler_unit.sv =====
// Top level of the CR/LF line assembler: front, command queue, line store and back.
// A raw word passes through the command queue into the output register. A line's words
// follow once its terminator is accepted, each read from the line store, then output.
// Throughput: one input word per cycle while the command queue has room; in line mode input
// stalls while a completed line is queued or being emitted from the line store.
// Reset: clears mode register, fill count, queue and output register; line store left as is.
module crlf_line_assembler_unit #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic clk,
    input  logic rst_n,
    cla_byte_if.sink   rx,
    cla_cfg_if.sink    cfg,
    cla_out_if.source  result
);

    localparam int LEN_W  = $clog2(LINE_CAPACITY);
    localparam int ADDR_W = $clog2(LINE_CAPACITY - 1);
    localparam int CMD_W  = 9 + LEN_W;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              cmd_push;
    logic [CMD_W-1:0]  cmd_push_data;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_valid;
    logic [CMD_W-1:0]  cmd_pop_data;
    logic              line_done;

    cla_front #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_push_data),
        .cmd_full  (cmd_full),
        .line_done (line_done)
    );

    cla_cmd_fifo #(
        .WIDTH(CMD_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_push_data),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .pop_data  (cmd_pop_data)
    );

    cla_ram #(
        .WIDTH(8),
        .DEPTH(LINE_CAPACITY - 1)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cla_back #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_pop_data),
        .cmd_pop   (cmd_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .line_done (line_done),
        .result    (result)
    );

endmodule

// ===== src/cla_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module cla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/cla_cmd_fifo.sv =====
// Two-entry command queue between the front and back parts.
module cla_cmd_fifo #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/cla_front.sv =====
// Front part: accepts bytes, holds the mode register, fills the line store, issues commands.
module cla_front #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic clk,
    input  logic rst_n,
    cla_byte_if.sink rx,
    cla_cfg_if.sink  cfg,
    output logic                                  ram_we,
    output logic [$clog2(LINE_CAPACITY-1)-1:0]    ram_waddr,
    output logic [7:0]                            ram_wdata,
    output logic                                  cmd_push,
    output logic [9+$clog2(LINE_CAPACITY)-1:0]    cmd_data,
    input  logic                                  cmd_full,
    input  logic                                  line_done
);

    localparam int LEN_W  = $clog2(LINE_CAPACITY);
    localparam int ADDR_W = $clog2(LINE_CAPACITY - 1);
    localparam logic [LEN_W-1:0] FILL_LIMIT = LEN_W'(LINE_CAPACITY - 1);

    logic             mode_reg;
    logic             mode_next;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;
    logic             busy_reg;
    logic             busy_next;
    logic             accept;
    logic             is_term;

    assign cfg.ready = 1'b1;
    assign rx.ready  = !cmd_full && (mode_reg || !busy_reg);
    assign accept    = rx.valid && rx.ready;
    assign is_term   = (rx.rx_byte == cla_pkg::CHAR_LF) || (rx.rx_byte == cla_pkg::CHAR_CR);

    assign ram_waddr = fill_reg[ADDR_W-1:0];
    assign ram_wdata = rx.rx_byte;

    always_comb
    begin
        mode_next = mode_reg;
        fill_next = fill_reg;
        busy_next = busy_reg;
        ram_we    = 1'b0;
        cmd_push  = 1'b0;
        cmd_data  = {cla_pkg::CMD_RAW, rx.rx_byte, {LEN_W{1'b0}}};
        if (cfg.valid)
        begin
            mode_next = cfg.passthrough_mode;
        end
        if (line_done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            if (mode_reg)
            begin
                cmd_push = 1'b1;
            end
            else if (fill_reg >= FILL_LIMIT)
            begin
                fill_next = '0;
            end
            else
            begin
                ram_we = 1'b1;
                if (is_term)
                begin
                    fill_next = '0;
                    if (fill_reg != '0)
                    begin
                        cmd_push  = 1'b1;
                        busy_next = 1'b1;
                        cmd_data  = {cla_pkg::CMD_LINE, rx.rx_byte, fill_reg + LEN_W'(1)};
                    end
                end
                else
                begin
                    fill_next = fill_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            fill_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== src/cla_back.sv =====
// Back part: executes queued commands, reads the line store and drives the result register.
module cla_back #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                                  cmd_valid,
    input  logic [9+$clog2(LINE_CAPACITY)-1:0]    cmd_data,
    output logic                                  cmd_pop,
    output logic                                  ram_re,
    output logic [$clog2(LINE_CAPACITY-1)-1:0]    ram_raddr,
    input  logic [7:0]                            ram_rdata,
    output logic                                  line_done,
    cla_out_if.source result
);

    localparam int LEN_W  = $clog2(LINE_CAPACITY);
    localparam int ADDR_W = $clog2(LINE_CAPACITY - 1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [LEN_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   idx_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic               valid_reg;
    logic               valid_next;
    logic [7:0]         byte_reg;
    logic [7:0]         byte_next;
    logic               kind_reg;
    logic               kind_next;
    logic               last_reg;
    logic               last_next;
    logic               out_free;
    logic               is_last;
    cla_pkg::cmd_kind_t cmd_kind;
    logic [7:0]         cmd_byte;
    logic [LEN_W-1:0]   cmd_len;

    assign cmd_kind  = cla_pkg::cmd_kind_t'(cmd_data[LEN_W+8]);
    assign cmd_byte  = cmd_data[LEN_W+7:LEN_W];
    assign cmd_len   = cmd_data[LEN_W-1:0];
    assign out_free  = !valid_reg || result.ready;
    assign is_last   = (idx_reg + LEN_W'(1)) == len_reg;
    assign ram_raddr = idx_reg[ADDR_W-1:0];

    assign result.valid      = valid_reg;
    assign result.out_byte   = byte_reg;
    assign result.out_kind   = kind_reg;
    assign result.end_of_run = last_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        cmd_pop    = 1'b0;
        ram_re     = 1'b0;
        line_done  = 1'b0;
        if (valid_reg && result.ready)
        begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_kind == cla_pkg::CMD_RAW)
                    begin
                        valid_next = 1'b1;
                        byte_next  = cmd_byte;
                        kind_next  = cla_pkg::KIND_RAW;
                        last_next  = 1'b1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        len_next   = cmd_len;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    byte_next  = ram_rdata;
                    kind_next  = cla_pkg::KIND_LINE;
                    last_next  = is_last;
                    if (is_last)
                    begin
                        line_done  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            len_reg   <= '0;
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            kind_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
            byte_reg  <= byte_next;
            kind_reg  <= kind_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the CR/LF line assembler: directed and random byte streams.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   LINE_CAP      = 64;
    localparam int   RANDOM_ITEMS  = 300;
    localparam int   CYCLE_LIMIT   = 600000;
    localparam int   SETTLE_CYCLES = 12;
    localparam logic MODE_LINE     = 1'b0;
    localparam logic MODE_RAW      = 1'b1;

    typedef struct packed
    {
        logic [7:0]         data;
        cla_pkg::out_kind_t kind;
        logic               last;
    } out_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cla_byte_if rx_if ();
    cla_cfg_if  cfg_if ();
    cla_out_if  res_if ();

    crlf_line_assembler_unit #(
        .LINE_CAPACITY(LINE_CAP)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .cfg    (cfg_if),
        .result (res_if)
    );

    out_word_t  pending_words[$];
    logic [7:0] line_copy[LINE_CAP];
    int         line_fill;
    logic       mode_copy;
    bit         idling;
    int         errors;
    int         bytes_sent;
    int         words_seen;
    int         lines_seen;
    int         raw_seen;
    int         stall_left;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (!idling)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cla_pkg::CHAR_CR || b == cla_pkg::CHAR_LF);
        return b;
    endfunction

    function automatic logic [7:0] pick_term();
        return ($urandom_range(0, 1) != 0) ? cla_pkg::CHAR_CR : cla_pkg::CHAR_LF;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $realtime, msg);
        errors++;
    endtask

    task automatic frame_byte(input logic [7:0] b);
        int n;
        if (mode_copy == MODE_RAW)
        begin
            pending_words.push_back('{data: b, kind: cla_pkg::KIND_RAW, last: 1'b1});
        end
        else if (line_fill >= LINE_CAP - 1)
        begin
            line_fill = 0;
        end
        else
        begin
            line_copy[line_fill] = b;
            line_fill++;
            if (b == cla_pkg::CHAR_CR || b == cla_pkg::CHAR_LF)
            begin
                n = line_fill;
                line_fill = 0;
                if (n > 1)
                    for (int i = 0; i < n; i++)
                        pending_words.push_back('{data: line_copy[i],
                                                  kind: cla_pkg::KIND_LINE,
                                                  last: (i == n - 1)});
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            rx_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do
            @(posedge clk);
        while (rx_if.ready !== 1'b1);
        bytes_sent++;
        frame_byte(b);
    endtask

    task automatic send_line(input int body_len, input logic [7:0] term);
        repeat (body_len) send_byte(body_byte());
        send_byte(term);
    endtask

    task automatic write_mode(input logic m);
        @(negedge clk);
        rx_if.valid = 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid            = 1'b1;
        cfg_if.passthrough_mode = m;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        mode_copy = m;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic test_line_basic();
        idling = 1'b0;
        send_byte("A");
        send_byte(cla_pkg::CHAR_CR);
    endtask

    task automatic test_lone_terminators();
        idling = 1'b1;
        send_byte(cla_pkg::CHAR_LF);
        send_byte("B");
        send_byte(cla_pkg::CHAR_CR);
        send_byte(cla_pkg::CHAR_LF);
    endtask

    task automatic test_byte_extremes();
        idling = 1'b0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cla_pkg::CHAR_LF);
    endtask

    task automatic test_passthrough();
        idling = 1'b1;
        write_mode(MODE_RAW);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cla_pkg::CHAR_CR);
        send_byte(cla_pkg::CHAR_LF);
        write_mode(MODE_LINE);
    endtask

    task automatic test_mode_resume();
        idling = 1'b1;
        send_byte("a");
        send_byte("b");
        write_mode(MODE_RAW);
        send_byte("x");
        write_mode(MODE_LINE);
        send_byte("c");
        send_byte(cla_pkg::CHAR_CR);
    endtask

    task automatic test_full_store();
        idling = 1'b1;
        send_line(LINE_CAP - 2, cla_pkg::CHAR_CR);
        repeat (LINE_CAP - 1) send_byte(body_byte());
        send_byte(cla_pkg::CHAR_CR);
        repeat (LINE_CAP) send_byte(body_byte());
        send_line(1, cla_pkg::CHAR_LF);
    endtask

    task automatic test_random_traffic();
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                idling = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_line($urandom_range(1, 10), pick_term());
            else if (pick < 62)
                send_line($urandom_range(11, LINE_CAP - 2), pick_term());
            else if (pick < 65)
                repeat ($urandom_range(LINE_CAP - 1, LINE_CAP + 2)) send_byte(body_byte());
            else if (pick < 75)
            begin
                send_line($urandom_range(0, 10), cla_pkg::CHAR_CR);
                send_byte(cla_pkg::CHAR_LF);
            end
            else if (pick < 80)
                send_byte(pick_term());
            else if (pick < 92)
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            else
            begin
                write_mode(MODE_RAW);
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
                write_mode(MODE_LINE);
            end
        end
    endtask

    initial
    begin
        res_if.ready = 1'b0;
        stall_left   = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready = 1'b1;
                if (idling && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap() + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %02h kind %b last %b",
                                          res_if.out_byte, res_if.out_kind,
                                          res_if.end_of_run));
            end
            else
            begin
                want = pending_words.pop_front();
                if (res_if.out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              res_if.out_byte, want.data));
                if (res_if.out_kind !== want.kind)
                    report_mismatch($sformatf("out_kind %b, want %b",
                                              res_if.out_kind, want.kind));
                if (res_if.end_of_run !== want.last)
                    report_mismatch($sformatf("end_of_run %b, want %b",
                                              res_if.end_of_run, want.last));
                if (want.kind == cla_pkg::KIND_RAW)
                    raw_seen++;
                else if (want.last)
                    lines_seen++;
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles with %0d words outstanding",
                 cycles, pending_words.size());
        $display("crlf_line_assembler_unit: mismatch");
        $finish;
    end

    initial
    begin
        rx_if.valid             = 1'b0;
        rx_if.rx_byte           = 8'h00;
        cfg_if.valid            = 1'b0;
        cfg_if.passthrough_mode = MODE_LINE;
        mode_copy               = MODE_LINE;
        line_fill               = 0;
        idling                  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_mode(MODE_LINE);
        test_line_basic();
        test_lone_terminators();
        test_byte_extremes();
        test_passthrough();
        test_mode_resume();
        test_full_store();
        test_random_traffic();

        @(negedge clk);
        rx_if.valid = 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Fed %0d bytes in line and passthrough modes, incl. full-store and CR LF cases",
                 bytes_sent);
        $display("Checked %0d words: %0d framed lines, %0d raw bytes; %0d errors",
                 words_seen, lines_seen, raw_seen, errors);
        if (errors == 0)
            $display("crlf_line_assembler_unit: match");
        else
            $display("crlf_line_assembler_unit: mismatch");
        $finish;
    end

endmodule
